>>> src/assert_macros.svh
// Assertion macros used by the checker file of the gap buffer store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define GBES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds during reset.
`define GBES_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gbes_pkg.sv
// Shared constants, codes and types of the gap buffer store.
package gbes_pkg;

   localparam int unsigned DEPTH  = 4096;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned POS_W  = 13;
   localparam int unsigned OFF_W  = 14;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OPC_W  = 3;
   localparam int unsigned STS_W  = 2;

   typedef enum logic [OPC_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_BACKSPACE = 3'd1,
      OP_MOVE      = 3'd2,
      OP_SETPOS    = 3'd3,
      OP_READ      = 3'd4
   } opcode_type;

   typedef enum logic [STS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_REFUSED  = 2'd1,
      ST_PAST_END = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPC_W-1:0]        opcode;
      logic [BYTE_W-1:0]       byte_in;
      logic signed [OFF_W-1:0] move_offset;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [BYTE_W-1:0] byte_out;
      logic [POS_W-1:0]  cursor_out;
      logic [POS_W-1:0]  length_out;
   } rsp_type;

endpackage

>>> src/gbes_if.sv
// Request and response channel interfaces of the gap buffer store.
interface gbes_req_if;
   logic                              valid;
   logic                              ready;
   logic [gbes_pkg::OPC_W-1:0]        opcode;
   logic [gbes_pkg::BYTE_W-1:0]       byte_in;
   logic signed [gbes_pkg::OFF_W-1:0] move_offset;
   logic [gbes_pkg::POS_W-1:0]        position;

   modport source (output valid, opcode, byte_in, move_offset, position, input ready);
   modport sink (input valid, opcode, byte_in, move_offset, position, output ready);
endinterface

interface gbes_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gbes_pkg::STS_W-1:0]  status;
   logic [gbes_pkg::BYTE_W-1:0] byte_out;
   logic [gbes_pkg::POS_W-1:0]  cursor_out;
   logic [gbes_pkg::POS_W-1:0]  length_out;

   modport source (output valid, status, byte_out, cursor_out, length_out, input ready);
   modport sink (input valid, status, byte_out, cursor_out, length_out, output ready);
endinterface

>>> src/gbes_ram.sv
// Simple dual-port byte memory with one write port and a registered read port.
module gbes_ram #(
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and read, read data held until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gbes_seq.sv
// Sequencer of the gap buffer: gap walk, edits and reads over one byte memory.
module gbes_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gbes_pkg::req_type req_data,
   input  logic              slot_free,
   output logic              done,
   output gbes_pkg::rsp_type rsp_data
);

   localparam int unsigned ADDR_W = gbes_pkg::ADDR_W;
   localparam int unsigned POS_W  = gbes_pkg::POS_W;
   localparam int unsigned OFF_W  = gbes_pkg::OFF_W;
   localparam int unsigned BYTE_W = gbes_pkg::BYTE_W;
   localparam int unsigned SUM_W  = ((POS_W + 1 > OFF_W) ? POS_W + 1 : OFF_W) + 1;
   localparam logic [POS_W-1:0] FULL_LEN = POS_W'(gbes_pkg::DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_RDATA = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Latched request
   gbes_pkg::opcode_type    op_ff;
   logic [BYTE_W-1:0]       byte_ff;
   logic signed [OFF_W-1:0] off_ff;
   logic [POS_W-1:0]        pos_ff;

   // Gap buffer pointers
   logic [POS_W-1:0] gs_ff, gs_in;
   logic [POS_W-1:0] gstop_ff, gstop_in;
   logic [POS_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] len_ff, len_in;

   // Pending write of a walked byte
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   // Memory port signals
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic signed [SUM_W-1:0] move_sum;
   logic [POS_W-1:0]        read_idx;

   gbes_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   // Cursor displacement and logical-to-physical read index
   assign move_sum = $signed(SUM_W'(cur_ff)) + SUM_W'(off_ff);
   assign read_idx = (pos_ff >= gs_ff) ? (pos_ff - gs_ff + gstop_ff) : pos_ff;

   // Next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      gs_in        = gs_ff;
      gstop_in     = gstop_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = gs_ff[ADDR_W-1:0];
      done         = 1'b0;
      rsp_data.status     = gbes_pkg::ST_DONE;
      rsp_data.byte_out   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (gbes_pkg::opcode_type'(req_data.opcode) == gbes_pkg::OP_INSERT ||
                   gbes_pkg::opcode_type'(req_data.opcode) == gbes_pkg::OP_BACKSPACE) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_WALK: begin
            // Retire the byte read in the previous step
            wr_en = pend_ff;
            if (cur_ff < gs_ff) begin
               // Shift the gap left by one byte
               rd_en        = 1'b1;
               rd_addr      = ADDR_W'(gs_ff - POS_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = ADDR_W'(gstop_ff - POS_W'(1));
               gs_in        = gs_ff - POS_W'(1);
               gstop_in     = gstop_ff - POS_W'(1);
            end else if (cur_ff > gs_ff) begin
               // Shift the gap right by one byte
               rd_en        = 1'b1;
               rd_addr      = gstop_ff[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = gs_ff[ADDR_W-1:0];
               gs_in        = gs_ff + POS_W'(1);
               gstop_in     = gstop_ff + POS_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  gbes_pkg::OP_INSERT: begin
                     if (len_ff == FULL_LEN) begin
                        rsp_data.status = gbes_pkg::ST_REFUSED;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = gs_ff[ADDR_W-1:0];
                        wr_data = byte_ff;
                        gs_in   = gs_ff + POS_W'(1);
                        cur_in  = cur_ff + POS_W'(1);
                        len_in  = len_ff + POS_W'(1);
                     end
                  end
                  gbes_pkg::OP_BACKSPACE: begin
                     if (len_ff == '0 || cur_ff == '0) begin
                        rsp_data.status = gbes_pkg::ST_REFUSED;
                     end else begin
                        gs_in  = gs_ff - POS_W'(1);
                        cur_in = cur_ff - POS_W'(1);
                        len_in = len_ff - POS_W'(1);
                     end
                  end
                  gbes_pkg::OP_MOVE: begin
                     if (move_sum < 0) begin
                        cur_in = '0;
                     end else if (move_sum > $signed(SUM_W'(len_ff))) begin
                        cur_in = len_ff;
                     end else begin
                        cur_in = move_sum[POS_W-1:0];
                     end
                  end
                  gbes_pkg::OP_SETPOS: begin
                     cur_in = (pos_ff > len_ff) ? len_ff : pos_ff;
                  end
                  gbes_pkg::OP_READ: begin
                     if (pos_ff >= len_ff) begin
                        rsp_data.status = gbes_pkg::ST_PAST_END;
                     end else begin
                        // Fetch the byte and answer from the read register in S_RDATA
                        done     = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = read_idx[ADDR_W-1:0];
                        state_in = S_RDATA;
                     end
                  end
                  default: begin
                     rsp_data.status = gbes_pkg::ST_REFUSED;
                  end
               endcase
            end
         end

         S_RDATA: begin
            if (slot_free) begin
               done              = 1'b1;
               rsp_data.byte_out = rd_data;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Report the pointers as they stand after the operation
      rsp_data.cursor_out = cur_in;
      rsp_data.length_out = len_in;
   end

   // Control and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gs_ff    <= '0;
         gstop_ff <= FULL_LEN;
         cur_ff   <= '0;
         len_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         gstop_ff <= gstop_in;
         cur_ff   <= cur_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
      end
   end

   // Latch the request and the pending write address
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (req_valid && req_ready) begin
         op_ff   <= gbes_pkg::opcode_type'(req_data.opcode);
         byte_ff <= req_data.byte_in;
         off_ff  <= req_data.move_offset;
         pos_ff  <= req_data.position;
      end
   end

endmodule

>>> src/gap_buffer_editor_store_core.sv
// Gap buffer byte store with cursor: request channel in, response register out.
// Move, set, spare opcodes and refused reads are answered from the execute state, a read
// after its byte returns from memory, insert and backspace after a gap walk to the cursor
// (the gap walk moves one byte per cycle through the memory ports). A new request is taken
// only once the last one is answered; a pending response does not stop the next request
// from being taken. Reset clears the pointers and control state; the byte memory is not
// cleared and needs no clearing pass.
module gap_buffer_editor_store_core (
   input logic        clock,
   input logic        reset,
   gbes_req_if.sink   req_ch,
   gbes_rsp_if.source rsp_ch
);

   gbes_pkg::req_type req_data;
   gbes_pkg::rsp_type seq_rsp;
   logic              seq_done;
   logic              slot_free;

   logic              out_valid_ff, out_valid_in;
   gbes_pkg::rsp_type out_data_ff;

   assign req_data.opcode      = req_ch.opcode;
   assign req_data.byte_in     = req_ch.byte_in;
   assign req_data.move_offset = req_ch.move_offset;
   assign req_data.position    = req_ch.position;

   gbes_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .done      (seq_done),
      .rsp_data  (seq_rsp)
   );

   // Response register is free when empty or being drained this cycle
   assign slot_free = !out_valid_ff || rsp_ch.ready;

   // Load a new response or drop the delivered one
   always_comb begin
      out_valid_in = out_valid_ff;
      if (seq_done) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         out_data_ff <= seq_rsp;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.status     = out_data_ff.status;
   assign rsp_ch.byte_out   = out_data_ff.byte_out;
   assign rsp_ch.cursor_out = out_data_ff.cursor_out;
   assign rsp_ch.length_out = out_data_ff.length_out;

endmodule

>>> src/gbes_checker.sv
// Port-level checks of the gap buffer store response channel, bound to the top.
`include "assert_macros.svh"

module gbes_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gbes_pkg::STS_W-1:0]  rsp_status,
   input logic [gbes_pkg::BYTE_W-1:0] rsp_byte_out,
   input logic [gbes_pkg::POS_W-1:0]  rsp_cursor_out,
   input logic [gbes_pkg::POS_W-1:0]  rsp_length_out
);

   localparam logic [gbes_pkg::POS_W-1:0] MAX_LEN = gbes_pkg::POS_W'(gbes_pkg::DEPTH);

   // Hold a response until it is taken
   `GBES_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

   // Keep cursor within the text and the text within capacity
   `GBES_ASSERT(a_bounds, clock, reset, rsp_valid |-> (rsp_cursor_out <= rsp_length_out) && (rsp_length_out <= MAX_LEN), "cursor or length out of range")

   // Use only defined status codes
   `GBES_ASSERT(a_status, clock, reset, rsp_valid |-> (rsp_status == gbes_pkg::ST_DONE) || (rsp_status == gbes_pkg::ST_REFUSED) || (rsp_status == gbes_pkg::ST_PAST_END), "bad status code")

   // Return a zero byte with every failed request
   `GBES_ASSERT(a_byte_zero, clock, reset, rsp_valid && (rsp_status != gbes_pkg::ST_DONE) |-> (rsp_byte_out == '0), "byte on failed request")

   // Come out of reset with no response pending
   `GBES_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind gap_buffer_editor_store_core gbes_checker u_gbes_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_byte_out   (rsp_ch.byte_out),
   .rsp_cursor_out (rsp_ch.cursor_out),
   .rsp_length_out (rsp_ch.length_out)
);
